### hw/rtl/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared types, operation codes and saturation helpers for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_GE       = 4'd5,
        OP_LT       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] val;
        logic        truth;
        logic [1:0]  st;
    } res_t;

    // Sign and magnitude to a saturated word.
    function automatic res_t sat_mag(input logic neg, input logic [63:0] mag);
        res_t r;
        r.truth = 1'b0;
        r.st    = ST_OK;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.val = WORD_MIN;
                r.st  = ST_OVF;
            end
            else begin
                r.val = 32'd0 - mag[31:0];
            end
        end
        else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                r.val = WORD_MAX;
                r.st  = ST_OVF;
            end
            else begin
                r.val = mag[31:0];
            end
        end
        return r;
    endfunction

    // 33-bit signed sum to a saturated word.
    function automatic res_t sat33(input logic [32:0] s);
        res_t r;
        r.truth = 1'b0;
        r.st    = ST_OK;
        r.val   = s[31:0];
        if (s[32] != s[31]) begin
            r.st  = ST_OVF;
            r.val = s[32] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

endpackage

### hw/rtl/fixed_point_q24_8_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// Pipelined signed fixed-point ALU: add, sub, mul, div, compare, min/max,
// step, and integer conversions, with saturation and status codes.
// ----------------------------------------------------------------------------
// Every transaction passes through the same pipeline of FRACTION_BITS+36
// register stages, so results leave in the order they entered and one
// transaction can be accepted every cycle unless out_stall holds a result.
// The length is set by the divider: it is a restoring divider with one
// quotient bit per stage, and the rounded quotient has FRACTION_BITS+33 bits.
// The multiplier splits the 32x32 magnitude product into two 32x16 partial
// products in one stage and sums and rounds them in the next. Products and
// quotients round to nearest with ties away from zero; results outside the
// 32-bit range saturate with status 1, division by zero gives status 2.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core
    import fxalu_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  operation,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic        truth,
    output logic [1:0]  status
);

    // Quotient width and stage layout:
    // stage 0 input, 1 decode, 2..QW+1 divider steps, QW+2 output.
    localparam int QW  = 33 + FRACTION_BITS;
    localparam int NST = QW + 3;
    localparam int LST = QW + 1;

    logic adv;
    logic [NST-1:0] vld_reg;

    // Advance the whole pipe unless the output holds a stalled result.
    assign adv      = !(vld_reg[NST-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // ---------------- stage 0: input register ----------------
    op_t         op0_reg;
    logic [31:0] a0_reg;
    logic [31:0] b0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg <= op_t'(operation);
            a0_reg  <= operand_a;
            b0_reg  <= operand_b;
        end
    end

    // ---------------- stage 1: decode and simple ops ----------------
    logic        [31:0] mag_a;
    logic        [31:0] mag_b;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [63:0] fi;
    res_t               res1_next;
    logic        [QW-1:0] x1_next;

    assign sa    = $signed(a0_reg);
    assign sb    = $signed(b0_reg);
    assign mag_a = a0_reg[31] ? 32'd0 - a0_reg : a0_reg;
    assign mag_b = b0_reg[31] ? 32'd0 - b0_reg : b0_reg;
    assign fi    = 64'(sa) <<< FRACTION_BITS;
    // Rounded dividend 2*|a|*2^F + |b|, divided later by 2*|b|.
    assign x1_next = QW'({mag_a, {(FRACTION_BITS + 1){1'b0}}}) + QW'(mag_b);

    always_comb
    begin
        res1_next = '0;
        case (op0_reg)
            OP_ADD: res1_next = sat33({a0_reg[31], a0_reg} + {b0_reg[31], b0_reg});
            OP_SUB: res1_next = sat33({a0_reg[31], a0_reg} - {b0_reg[31], b0_reg});
            OP_DIV:
            begin
                if (b0_reg == 32'd0)
                begin
                    res1_next.st  = ST_DIV0;
                    res1_next.val = a0_reg[31] ? WORD_MIN :
                                    ((a0_reg == 32'd0) ? 32'd0 : WORD_MAX);
                end
            end
            OP_GT: res1_next.truth = sa > sb;
            OP_GE: res1_next.truth = sa >= sb;
            OP_LT: res1_next.truth = sa < sb;
            OP_LE: res1_next.truth = sa <= sb;
            OP_EQ: res1_next.truth = sa == sb;
            OP_NE: res1_next.truth = sa != sb;
            OP_MIN: res1_next.val = (sa < sb) ? a0_reg : b0_reg;
            OP_MAX: res1_next.val = (sa > sb) ? a0_reg : b0_reg;
            OP_INC: res1_next = sat33({a0_reg[31], a0_reg} + 33'd1);
            OP_DEC: res1_next = sat33({a0_reg[31], a0_reg} - 33'd1);
            OP_TO_INT: res1_next.val = 32'(sa >>> FRACTION_BITS);
            OP_FROM_INT:
            begin
                if (fi[63:31] != {33{fi[63]}})
                begin
                    res1_next.st  = ST_OVF;
                    res1_next.val = a0_reg[31] ? WORD_MIN : WORD_MAX;
                end
                else
                begin
                    res1_next.val = fi[31:0];
                end
            end
            default: res1_next = '0;
        endcase
    end

    res_t              res_reg    [1:LST];
    logic              dsel_reg   [1:LST];
    logic              dneg_reg   [1:LST];
    logic [32:0]       rem_reg    [1:LST-1];
    logic [QW-1:0]     dq_reg     [1:LST];
    logic [32:0]       dvs_reg    [1:LST-1];
    logic              is_mul_reg;
    logic              mneg_reg;
    logic [47:0]       pp_lo_reg;
    logic [47:0]       pp_hi_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg[1]  <= res1_next;
            dsel_reg[1] <= (op0_reg == OP_DIV) && (b0_reg != 32'd0);
            dneg_reg[1] <= a0_reg[31] ^ b0_reg[31];
            rem_reg[1]  <= '0;
            dq_reg[1]   <= x1_next;
            dvs_reg[1]  <= {mag_b, 1'b0};
            is_mul_reg  <= (op0_reg == OP_MUL);
            mneg_reg    <= a0_reg[31] ^ b0_reg[31];
            pp_lo_reg   <= mag_a * mag_b[15:0];
            pp_hi_reg   <= mag_a * mag_b[31:16];
        end
    end

    // ---------------- stage 2: finish multiply ----------------
    logic [63:0] prod;
    logic [63:0] prod_rnd;
    res_t        mul_res;

    assign prod     = {16'd0, pp_lo_reg} + {pp_hi_reg, 16'd0};
    assign prod_rnd = (prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    assign mul_res  = sat_mag(mneg_reg, prod_rnd);

    // ---------------- stages 2..QW+1: divider, one bit each ----------------
    genvar k;
    generate
        for (k = 2; k <= LST; k++)
        begin : g_div
            logic [33:0] trial;
            logic        qbit;
            assign trial = {rem_reg[k-1], dq_reg[k-1][QW-1]};
            assign qbit  = trial >= {1'b0, dvs_reg[k-1]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (k == 2)
                    begin
                        res_reg[k] <= is_mul_reg ? mul_res : res_reg[k-1];
                    end
                    else
                    begin
                        res_reg[k] <= res_reg[k-1];
                    end
                    dsel_reg[k] <= dsel_reg[k-1];
                    dneg_reg[k] <= dneg_reg[k-1];
                    dq_reg[k]   <= {dq_reg[k-1][QW-2:0], qbit};
                end
            end

            // Carry remainder and divisor only to steps that still need them.
            if (k < LST)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        dvs_reg[k] <= dvs_reg[k-1];
                        rem_reg[k] <= qbit ? 33'(trial - {1'b0, dvs_reg[k-1]})
                                           : trial[32:0];
                    end
                end
            end
        end
    endgenerate

    // ---------------- output stage ----------------
    res_t out_next;
    res_t out_reg;

    assign out_next = dsel_reg[LST] ? sat_mag(dneg_reg[LST], 64'(dq_reg[LST]))
                                    : res_reg[LST];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign value     = out_reg.val;
    assign truth     = out_reg.truth;
    assign status    = out_reg.st;

`ifndef SYNTH
    // A held result must hold the input side too.
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input accepted while output stalled");

    // A stalled result keeps its valid and its value.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(value) && $stable(status)))
        else $error("stalled result changed");

    // A comparison outcome comes with a zero value and good status.
    a_truth_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && truth) |-> (value == 32'd0 && status == ST_OK))
        else $error("truth set with nonzero value or status");

    // Divide by zero yields only a saturated word or zero.
    a_div0_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_DIV0) |->
            (value == WORD_MAX || value == WORD_MIN || value == 32'd0))
        else $error("bad divide-by-zero value");
`endif

endmodule
